// ----- hdl/fvws_pkg.sv -----
// Shared types and constants of the four-voice wavetable synthesizer.
package fvws_pkg;

  // Kind of an input transaction, carried on s_axis_tuser.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_NOTE      = 2'd1,
    OP_LOAD_WAVE = 2'd2,
    OP_LOAD_ENV  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WAVE_LENGTH    = 1'b0,
    REG_ENV_HOLD_INDEX = 1'b1
  } reg_e;

  localparam logic [7:0]  WAVE_LENGTH_RST = 8'h79;
  localparam logic [6:0]  ENV_HOLD_RST    = 7'h7F;
  localparam logic [15:0] TICK_COUNT_RST  = 16'hFFFE;
  localparam logic [15:0] TICK_LIMIT_RST  = 16'hFFFF;
  localparam logic [7:0]  LEVEL_OFFSET    = 8'h80;
  localparam logic [7:0]  LEVEL_STOPPED   = 8'h80;
  localparam int          LEVEL_SHIFT     = 2;

  // Per-voice control, driven by the top level for each accepted transaction.
  typedef struct packed {
    logic        tick;         // sample tick while playing: advance the voice
    logic        read;         // sample tick: read the tables at the old position
    logic        note;         // restart this voice
    logic        load_wave;    // write the wave table copy
    logic        load_env;     // write the envelope table copy
    logic [15:0] step;
    logic [6:0]  index;
    logic [7:0]  value;
    logic [7:0]  wave_length;
    logic [6:0]  env_hold;
  } ctrl_t;

endpackage

// ----- hdl/fvws_voice.sv -----
// One voice: phase and envelope counters with private copies of both tables.
module fvws_voice #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fvws_pkg::ctrl_t ctrl_i,
  output logic [7:0]      wave_byte_o,
  output logic [7:0]      env_byte_o
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  logic [15:0] phase_q, phase_d;
  logic [15:0] env_q, env_d;
  logic [15:0] step_q, step_d;

  logic [7:0] wave_mem [TABLE_DEPTH];
  logic [7:0] env_mem  [TABLE_DEPTH];
  logic [7:0] wave_rd_q;
  logic [7:0] env_rd_q;

  // Constant table that folds a high byte into the table range.
  logic [IdxW-1:0] fold_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_fold
    assign fold_lut[g] = IdxW'(g % TABLE_DEPTH);
  end

  logic [15:0]   ph_sum;
  logic [7:0]    ph_hi;
  logic [IdxW-1:0] wr_addr;

  assign wr_addr = IdxW'(ctrl_i.index);

  // Next phase, envelope and step.
  always_comb begin
    ph_sum = phase_q + step_q;
    ph_hi  = ph_sum[15:8];
    if (ph_hi >= ctrl_i.wave_length) begin
      ph_hi = ph_hi - ctrl_i.wave_length;
    end
    phase_d = phase_q;
    env_d   = env_q;
    step_d  = step_q;
    if (ctrl_i.note) begin
      phase_d = '0;
      env_d   = '0;
      step_d  = ctrl_i.step;
    end else if (ctrl_i.tick) begin
      phase_d = {ph_hi, ph_sum[7:0]};
      if (env_q[15:8] < {1'b0, ctrl_i.env_hold}) begin
        env_d = env_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      env_q   <= '0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      env_q   <= env_d;
      step_q  <= step_d;
    end
  end

  // Table copies: one write port, written alike in every voice, and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_wave) begin
      wave_mem[wr_addr] <= ctrl_i.value;
    end
    if (ctrl_i.load_env) begin
      env_mem[wr_addr] <= ctrl_i.value;
    end
    if (ctrl_i.read) begin
      wave_rd_q <= wave_mem[fold_lut[phase_q[15:8]]];
      env_rd_q  <= env_mem[fold_lut[env_q[15:8]]];
    end
  end

  assign wave_byte_o = wave_rd_q;
  assign env_byte_o  = env_rd_q;

endmodule

// ----- hdl/fvws_mix.sv -----
// Mixer: scales each wave byte by its envelope and sums the voices into a level.
module fvws_mix #(
  parameter int NUM_VOICES = 4
) (
  input  logic [NUM_VOICES-1:0][7:0] wave_byte_i,
  input  logic [NUM_VOICES-1:0][7:0] env_byte_i,
  output logic [7:0]                 level_o
);

  logic signed [16:0] prod [NUM_VOICES];
  logic [7:0]         sum;
  logic [7:0]         biased;

  // Floor of product / 256 is the arithmetic shift; only its low byte matters.
  always_comb begin
    sum = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      prod[v] = $signed({wave_byte_i[v][7], wave_byte_i[v]}) *
                $signed({1'b0, env_byte_i[v]});
      sum     = sum + prod[v][15:8];
    end
    biased  = sum + fvws_pkg::LEVEL_OFFSET;
    level_o = biased >> fvws_pkg::LEVEL_SHIFT;
  end

endmodule

// ----- hdl/four_voice_wavetable_synth.sv -----
// Top level of the four-voice wavetable synthesizer.
//
// Input transactions arrive on the s_axis channel; s_axis_tuser gives the kind
// (sample tick, note event, wave table load, envelope table load). Only a
// sample tick produces an output transaction on m_axis: the PWM level, the
// note_due flag and the playing flag. Other kinds produce nothing.
// An accepted tick passes through the table-read stage and then the output
// register before m_axis_tvalid rises: the voice tables are read into
// registers at acceptance, and the mixer output is then captured in the
// output register. While s_axis_tready is high, one transaction is accepted
// every cycle; each voice's table copy has a registered read port, one per
// voice and table.
// While m_axis is stalled, one tick sits in the table-read stage and one in
// the output register; s_axis_tready drops only when both are full.
// Reset clears the voices, sets the duration counter to expire on the first
// tick and starts playback; the tables hold nothing until loaded. The
// configuration port takes wave_length (index 0) and env_hold_index (index 1).
module four_voice_wavetable_synth #(
  parameter int NUM_VOICES     = 4,
  parameter int TABLE_DEPTH    = 128,
  parameter int DURATION_SHIFT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: voice[1:0], phase_step[17:2], duration[25:18],
  // table_index[32:26], table_value[40:33], zero fill [47:41].
  input  logic [47:0] s_axis_tdata,
  // tuser: op[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: pwm_level[7:0], note_due[8], playing[9], zero fill [15:10].
  output logic [15:0] m_axis_tdata
);

  // Unpack the input transaction.
  logic [1:0]  in_voice;
  logic [15:0] in_step;
  logic [7:0]  in_duration;
  logic [6:0]  in_index;
  logic [7:0]  in_value;
  fvws_pkg::op_e in_op;

  assign in_voice    = s_axis_tdata[1:0];
  assign in_step     = s_axis_tdata[17:2];
  assign in_duration = s_axis_tdata[25:18];
  assign in_index    = s_axis_tdata[32:26];
  assign in_value    = s_axis_tdata[40:33];
  assign in_op       = fvws_pkg::op_e'(s_axis_tuser);

  // Configuration registers.
  logic [7:0] wave_length_q;
  logic [6:0] env_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_length_q <= fvws_pkg::WAVE_LENGTH_RST;
      env_hold_q    <= fvws_pkg::ENV_HOLD_RST;
    end else if (cfg_we_i) begin
      case (fvws_pkg::reg_e'(cfg_addr_i))
        fvws_pkg::REG_WAVE_LENGTH:    wave_length_q <= cfg_wdata_i;
        fvws_pkg::REG_ENV_HOLD_INDEX: env_hold_q    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: read stage, then output register.
  logic s1_valid_q, s1_due_q, s1_play_q;
  logic out_valid_q;
  logic [15:0] out_data_q;
  logic s1_move, accept, is_tick, is_note;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = accept && (in_op == fvws_pkg::OP_TICK);
  assign is_note       = accept && (in_op == fvws_pkg::OP_NOTE);

  // Playback state and duration counter.
  logic        active_q, active_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [15:0] tick_limit_q, tick_limit_d;
  logic [15:0] count_inc;
  logic        due;
  logic        restart;

  always_comb begin
    active_d     = active_q;
    tick_count_d = tick_count_q;
    tick_limit_d = tick_limit_q;
    count_inc    = tick_count_q + 16'd1;
    due          = 1'b0;
    restart      = 1'b0;
    if (is_tick && active_q) begin
      if (count_inc >= tick_limit_q) begin
        tick_count_d = '0;
        due          = 1'b1;
      end else begin
        tick_count_d = count_inc;
      end
    end else if (is_note && active_q) begin
      if (in_duration == 8'd0) begin
        active_d     = 1'b0;
        tick_count_d = fvws_pkg::TICK_COUNT_RST;
      end else begin
        tick_limit_d = 16'(in_duration) << DURATION_SHIFT;
        restart      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b1;
      tick_count_q <= fvws_pkg::TICK_COUNT_RST;
      tick_limit_q <= fvws_pkg::TICK_LIMIT_RST;
    end else begin
      active_q     <= active_d;
      tick_count_q <= tick_count_d;
      tick_limit_q <= tick_limit_d;
    end
  end

  // Table loads only within range; the index field can exceed a table shallower than 128 entries.
  logic load_ok;
  assign load_ok = 32'(in_index) < TABLE_DEPTH;

  // Per-voice control and the voices themselves.
  fvws_pkg::ctrl_t ctrl [NUM_VOICES];
  logic [NUM_VOICES-1:0][7:0] wave_bytes;
  logic [NUM_VOICES-1:0][7:0] env_bytes;

  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      ctrl[v].tick        = is_tick && active_q;
      ctrl[v].read        = is_tick;
      ctrl[v].note        = restart && (32'(in_voice) == v);
      ctrl[v].load_wave   = accept && (in_op == fvws_pkg::OP_LOAD_WAVE) && load_ok;
      ctrl[v].load_env    = accept && (in_op == fvws_pkg::OP_LOAD_ENV) && load_ok;
      ctrl[v].step        = in_step;
      ctrl[v].index       = in_index;
      ctrl[v].value       = in_value;
      ctrl[v].wave_length = wave_length_q;
      ctrl[v].env_hold    = env_hold_q;
    end
  end

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_voice
    fvws_voice #(
      .TABLE_DEPTH(TABLE_DEPTH)
    ) u_voice (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .wave_byte_o(wave_bytes[g]),
      .env_byte_o (env_bytes[g])
    );
  end

  logic [7:0] mix_level;

  fvws_mix #(
    .NUM_VOICES(NUM_VOICES)
  ) u_mix (
    .wave_byte_i(wave_bytes),
    .env_byte_i (env_bytes),
    .level_o    (mix_level)
  );

  // Read stage flags travel beside the table read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_due_q   <= 1'b0;
      s1_play_q  <= 1'b0;
    end else if (is_tick) begin
      s1_valid_q <= 1'b1;
      s1_due_q   <= due;
      s1_play_q  <= active_q;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Output register.
  logic [7:0] level;
  assign level = s1_play_q ? mix_level : fvws_pkg::LEVEL_STOPPED;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= {6'd0, s1_play_q, s1_due_q, level};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
